### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define PLAS_CHECK(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define PLAS_CHECK_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define PLAS_CHECK(lbl, pre, post)
`define PLAS_CHECK_NEXT(lbl, pre, post)
`endif
`endif

### hw/rtl/plas_pkg.sv
package plas_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BEYOND = 2'd1;
  localparam logic [1:0] ST_FEW    = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [31:0] TAN_ONE = 32'd16384;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [31:0]        arc_pos;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_y;
    logic [9:0]         seg_index;
    logic [31:0]        total_len;
    logic [1:0]         status;
  } out_item_t;

  // One row of the vertex table.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] cum;
  } vert_entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_AP_RD, S_SR_ISSUE, S_SR_CMP, S_RD0, S_RD1, S_RD2, S_DIF,
    S_SQX, S_SQY, S_SUM, S_SQ_CHK, S_SQW, S_AP_WR, S_OP, S_OPM, S_DIVW,
    S_FIN, S_OUT
  } state_t;

endpackage

### hw/rtl/plas_ram.sv
module plas_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, read one entry with a registered output.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/plas_sqrt.sv
module plas_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] din,
  output logic        busy,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] src_r;
  logic [35:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [35:0] rem_t;
  logic [35:0] trial;

  // Bring down two bits and try the next root bit.
  assign rem_t = {rem_r[33:0], src_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src_r  <= din;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= 5'd31;
    end else if (busy_r) begin
      src_r <= {src_r[61:0], 2'b00};
      cnt_r <= cnt_r - 5'd1;
      if (rem_t >= trial) begin
        rem_r  <= rem_t - trial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_t;
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

### hw/rtl/plas_div.sv
module plas_div #(
  parameter int DW = 65,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CNT_W = $clog2(DW);

  logic [DW-1:0]    src_r;
  logic [DW-1:0]    q_r;
  logic [VW:0]      rem_r;
  logic [VW-1:0]    dv_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [VW:0]      rem_t;

  // Shift in one dividend bit and subtract when it fits.
  assign rem_t = {rem_r[VW-1:0], src_r[DW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src_r <= dividend;
      dv_r  <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= CNT_W'(DW - 1);
    end else if (busy_r) begin
      src_r <= {src_r[DW-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
      if (rem_t >= {1'b0, dv_r}) begin
        rem_r <= rem_t - {1'b0, dv_r};
        q_r   <= {q_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rem_t;
        q_r   <= {q_r[DW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### hw/rtl/polyline_arc_length_sampler.sv
// Polyline arc-length sampler.
// Input channel in_valid/in_ready/in_data carries commands: clear, append a
// vertex, or sample the polyline at an arc length. Every command gives one
// beat on out_valid/out_ready/out_data.
// Vertices and cumulative lengths sit in one single-port-read table.
// Clear, the unused code, an error status and the first append go straight to
// the output beat. Other appends read the last vertex, square the deltas, run
// the 32-step square root unit, then write the table and load the beat (the
// root is skipped when the sum of squares saturates). Sample runs a binary
// search (at most 11 steps for 1024 vertices), closes the search, reads the
// segment, squares the deltas and takes the square root (halving the deltas
// first when their squares overflow), runs four divisions on the 65-step
// bit-serial divider (each skipped when its divisor is zero), then forms and
// loads the beat. The next command is taken in the cycle after the beat moves
// into the output register.
// Reset empties the polyline (count and total length zero) and drops any
// pending output beat; table contents need no clearing.
// When the receiver stalls, the output beat holds; one more command may be
// accepted and processed, then the block waits until the beat is taken.
module polyline_arc_length_sampler #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plas_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output plas_pkg::out_item_t out_data
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int EW = $bits(plas_pkg::vert_entry_t);

  plas_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       count_r;
  logic [31:0]         total_r;
  logic                out_valid_r;
  plas_pkg::out_item_t out_r;
  plas_pkg::out_item_t res_r;
  plas_pkg::out_item_t res_nxt;

  logic [1:0]  cmd_r;
  logic [31:0] vx_r, vy_r, s_r;
  logic [CW-1:0] lo_r, hi_r, mid_r, mid;
  logic [AW-1:0] idx_r;
  logic [CW-1:0] idx_sel;
  logic [31:0] x0_r, y0_r, c0_r, x1_r, y1_r, c1_r;
  logic        dxneg_r, dyneg_r;
  logic [31:0] mx_r, my_r, ax_r, ay_r;
  logic [63:0] sqx_r, prod_r;
  logic [64:0] sum_r;
  logic [31:0] len_r;
  logic [1:0]  j_r;
  logic [31:0] qpx_r, qpy_r, qtx_r, qty_r;

  logic        accept;
  logic        is_sample;
  logic        full;
  logic        we;
  logic [AW-1:0] raddr;
  plas_pkg::vert_entry_t wentry, rd;
  logic [EW-1:0] rdata;
  logic [32:0] dx, dy, mdx, mdy;
  logic [32:0] csum;
  logic [31:0] cnew;
  logic [31:0] num, den;
  logic [31:0] op_a, op_b, op_v;
  logic [31:0] mul_a, mul_b;
  logic        sq_start, sq_busy, sq_done;
  logic [31:0] sq_root;
  logic        div_start, div_done;
  logic [64:0] div_q;
  logic [AW+9:0] seg_ext;

  assign accept    = in_valid && in_ready;
  assign is_sample = (cmd_r == plas_pkg::CMD_SAMPLE);
  assign full      = (count_r == CW'(MAX_VERTICES));
  assign rd        = rdata;
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);

  // Segment differences and magnitudes.
  assign dx  = {x1_r[31], x1_r} - {x0_r[31], x0_r};
  assign dy  = {y1_r[31], y1_r} - {y0_r[31], y0_r};
  assign mdx = dx[32] ? (33'd0 - dx) : dx;
  assign mdy = dy[32] ? (33'd0 - dy) : dy;

  // Saturating cumulative length.
  assign csum = {1'b0, c0_r} + {1'b0, len_r};
  assign cnew = csum[32] ? 32'hFFFF_FFFF : csum[31:0];

  assign num = s_r - c0_r;
  assign den = c1_r - c0_r;

  // Operands of the four divisions.
  always_comb begin
    case (j_r)
      2'd0:    begin op_a = mx_r; op_b = num; op_v = den; end
      2'd1:    begin op_a = my_r; op_b = num; op_v = den; end
      2'd2:    begin op_a = ax_r; op_b = plas_pkg::TAN_ONE; op_v = len_r; end
      default: begin op_a = ay_r; op_b = plas_pkg::TAN_ONE; op_v = len_r; end
    endcase
  end

  // Shared multiplier, registered.
  always_comb begin
    case (state_r)
      plas_pkg::S_SQX: begin mul_a = ax_r; mul_b = ax_r; end
      plas_pkg::S_SQY: begin mul_a = ay_r; mul_b = ay_r; end
      default:         begin mul_a = op_a; mul_b = op_b; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Last-vertex index after the search, stepped back at the end.
  always_comb begin
    idx_sel = lo_r - 1'b1;
    if (idx_sel == count_r - 1'b1) begin
      idx_sel = idx_sel - 1'b1;
    end
  end

  // Next state and control.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    we        = 1'b0;
    raddr     = idx_r;
    sq_start  = 1'b0;
    div_start = 1'b0;
    wentry.x  = vx_r;
    wentry.y  = vy_r;
    wentry.cum = cnew;
    unique case (state_r)
      plas_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        raddr      = AW'(count_r - 1'b1);
        wentry.x   = in_data.vx;
        wentry.y   = in_data.vy;
        wentry.cum = '0;
        if (in_valid) begin
          state_nxt = plas_pkg::S_OUT;
          if (in_data.cmd == plas_pkg::CMD_APPEND && !full) begin
            if (count_r == '0) begin
              we = 1'b1;
            end else begin
              state_nxt = plas_pkg::S_AP_RD;
            end
          end else if (in_data.cmd == plas_pkg::CMD_SAMPLE && count_r >= CW'(2) &&
                       in_data.arc_pos <= total_r) begin
            state_nxt = plas_pkg::S_SR_ISSUE;
          end
        end
      end
      plas_pkg::S_AP_RD: state_nxt = plas_pkg::S_DIF;
      plas_pkg::S_SR_ISSUE: begin
        raddr = mid[AW-1:0];
        if (lo_r < hi_r) begin
          state_nxt = plas_pkg::S_SR_CMP;
        end else begin
          state_nxt = plas_pkg::S_RD0;
        end
      end
      plas_pkg::S_SR_CMP: state_nxt = plas_pkg::S_SR_ISSUE;
      plas_pkg::S_RD0: begin
        raddr     = idx_r;
        state_nxt = plas_pkg::S_RD1;
      end
      plas_pkg::S_RD1: begin
        raddr     = idx_r + 1'b1;
        state_nxt = plas_pkg::S_RD2;
      end
      plas_pkg::S_RD2:  state_nxt = plas_pkg::S_DIF;
      plas_pkg::S_DIF:  state_nxt = plas_pkg::S_SQX;
      plas_pkg::S_SQX:  state_nxt = plas_pkg::S_SQY;
      plas_pkg::S_SQY:  state_nxt = plas_pkg::S_SUM;
      plas_pkg::S_SUM:  state_nxt = plas_pkg::S_SQ_CHK;
      plas_pkg::S_SQ_CHK: begin
        if (sum_r[64]) begin
          state_nxt = is_sample ? plas_pkg::S_SQX : plas_pkg::S_AP_WR;
        end else begin
          sq_start  = 1'b1;
          state_nxt = plas_pkg::S_SQW;
        end
      end
      plas_pkg::S_SQW: begin
        if (sq_done) begin
          state_nxt = is_sample ? plas_pkg::S_OP : plas_pkg::S_AP_WR;
        end
      end
      plas_pkg::S_AP_WR: begin
        we        = 1'b1;
        state_nxt = plas_pkg::S_OUT;
      end
      plas_pkg::S_OP: state_nxt = plas_pkg::S_OPM;
      plas_pkg::S_OPM: begin
        if (op_v != '0) begin
          div_start = 1'b1;
          state_nxt = plas_pkg::S_DIVW;
        end else begin
          state_nxt = (j_r == 2'd3) ? plas_pkg::S_FIN : plas_pkg::S_OP;
        end
      end
      plas_pkg::S_DIVW: begin
        if (div_done) begin
          state_nxt = (j_r == 2'd3) ? plas_pkg::S_FIN : plas_pkg::S_OP;
        end
      end
      plas_pkg::S_FIN: state_nxt = plas_pkg::S_OUT;
      plas_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = plas_pkg::S_IDLE;
        end
      end
      default: state_nxt = plas_pkg::S_IDLE;
    endcase
  end

  // Result fields: open in idle, total on append, point, tangent, segment at finish.
  always_comb begin
    res_nxt = res_r;
    case (state_r)
      plas_pkg::S_IDLE: begin
        res_nxt = '0;
        res_nxt.total_len = (in_data.cmd == plas_pkg::CMD_CLEAR) ? 32'd0 : total_r;
        if (in_data.cmd == plas_pkg::CMD_APPEND && full) begin
          res_nxt.status = plas_pkg::ST_FULL;
        end else if (in_data.cmd == plas_pkg::CMD_SAMPLE) begin
          if (count_r < CW'(2)) begin
            res_nxt.status = plas_pkg::ST_FEW;
          end else if (in_data.arc_pos > total_r) begin
            res_nxt.status = plas_pkg::ST_BEYOND;
          end
        end
      end
      plas_pkg::S_AP_WR: res_nxt.total_len = cnew;
      plas_pkg::S_FIN: begin
        res_nxt.px        = dxneg_r ? (x0_r - qpx_r) : (x0_r + qpx_r);
        res_nxt.py        = dyneg_r ? (y0_r - qpy_r) : (y0_r + qpy_r);
        res_nxt.tan_x     = dxneg_r ? (16'd0 - qtx_r[15:0]) : qtx_r[15:0];
        res_nxt.tan_y     = dyneg_r ? (16'd0 - qty_r[15:0]) : qty_r[15:0];
        res_nxt.seg_index = seg_ext[9:0];
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plas_pkg::S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_data.cmd == plas_pkg::CMD_CLEAR) begin
        count_r <= '0;
        total_r <= '0;
      end else if (we) begin
        count_r <= count_r + 1'b1;
        total_r <= wentry.cum;
      end
      if (state_r == plas_pkg::S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    case (state_r)
      plas_pkg::S_IDLE: begin
        cmd_r <= in_data.cmd;
        vx_r  <= in_data.vx;
        vy_r  <= in_data.vy;
        s_r   <= in_data.arc_pos;
        lo_r  <= '0;
        hi_r  <= count_r;
      end
      plas_pkg::S_AP_RD: begin
        x0_r <= rd.x;
        y0_r <= rd.y;
        c0_r <= rd.cum;
        x1_r <= vx_r;
        y1_r <= vy_r;
      end
      plas_pkg::S_SR_ISSUE: begin
        mid_r <= mid;
        idx_r <= idx_sel[AW-1:0];
      end
      plas_pkg::S_SR_CMP: begin
        if (rd.cum > s_r) begin
          hi_r <= mid_r;
        end else begin
          lo_r <= mid_r + 1'b1;
        end
      end
      plas_pkg::S_RD1: begin
        x0_r <= rd.x;
        y0_r <= rd.y;
        c0_r <= rd.cum;
      end
      plas_pkg::S_RD2: begin
        x1_r <= rd.x;
        y1_r <= rd.y;
        c1_r <= rd.cum;
      end
      plas_pkg::S_DIF: begin
        dxneg_r <= dx[32];
        dyneg_r <= dy[32];
        mx_r    <= mdx[31:0];
        my_r    <= mdy[31:0];
        ax_r    <= mdx[31:0];
        ay_r    <= mdy[31:0];
      end
      plas_pkg::S_SQY: sqx_r <= prod_r;
      plas_pkg::S_SUM: sum_r <= {1'b0, sqx_r} + {1'b0, prod_r};
      plas_pkg::S_SQ_CHK: begin
        // Sum of squares too wide: saturate on append, halve on sample.
        if (sum_r[64]) begin
          len_r <= 32'hFFFF_FFFF;
          ax_r  <= {1'b0, ax_r[31:1]};
          ay_r  <= {1'b0, ay_r[31:1]};
        end
      end
      plas_pkg::S_SQW: begin
        if (sq_done) begin
          len_r <= sq_root;
          j_r   <= 2'd0;
        end
      end
      plas_pkg::S_OPM: begin
        if (op_v == '0) begin
          case (j_r)
            2'd0:    qpx_r <= '0;
            2'd1:    qpy_r <= '0;
            2'd2:    qtx_r <= '0;
            default: qty_r <= '0;
          endcase
          j_r <= j_r + 2'd1;
        end
      end
      plas_pkg::S_DIVW: begin
        if (div_done) begin
          case (j_r)
            2'd0:    qpx_r <= div_q[31:0];
            2'd1:    qpy_r <= div_q[31:0];
            2'd2:    qtx_r <= div_q[31:0];
            default: qty_r <= div_q[31:0];
          endcase
          j_r <= j_r + 2'd1;
        end
      end
      plas_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_r <= res_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign seg_ext = {10'd0, idx_r};

  plas_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_VERTICES)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(count_r[AW-1:0]),
    .wdata(wentry),
    .raddr(raddr),
    .rdata(rdata)
  );

  plas_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .din  (sum_r[63:0]),
    .busy (sq_busy),
    .done (sq_done),
    .root (sq_root)
  );

  plas_div #(
    .DW(65),
    .VW(32)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend({1'b0, prod_r} + {33'd0, op_v >> 1}),
    .divisor (op_v),
    .done    (div_done),
    .quot    (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PLAS_CHECK(a_search_open, state_r == plas_pkg::S_SR_CMP, lo_r < hi_r)
  `PLAS_CHECK(a_seg_in_table, state_r == plas_pkg::S_RD1, (CW'(idx_r) + 1'b1) < count_r)
  `PLAS_CHECK(a_div_nonzero, div_start, op_v != '0)
  `PLAS_CHECK(a_sqrt_free, sq_start, !sq_busy)
  `PLAS_CHECK_NEXT(a_out_load, state_r == plas_pkg::S_OUT && (!out_valid_r || out_ready),
                   out_valid_r && state_r == plas_pkg::S_IDLE)

endmodule
